@@ rtl/gne_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gne_pkg;

    localparam int C_COORD_W  = 12;
    localparam int C_SIZE_W   = 13;
    localparam int C_PAT_W    = 2;
    localparam int C_SLOTS    = 24;
    localparam int C_SLOT_W   = $clog2(C_SLOTS);
    localparam int C_REACH_N  = 5;    // offsets -2..+2 along one axis
    localparam int C_OFF_W    = $clog2(C_REACH_N);

    // map size is capped at the largest map and at the coordinate span
    localparam int C_MAP_MAX    = 4096;
    localparam int C_COORD_SPAN = 4096;
    localparam logic [C_SIZE_W-1:0] C_SIZE_CAP =
        C_SIZE_W'((C_MAP_MAX < C_COORD_SPAN) ? C_MAP_MAX : C_COORD_SPAN);
    localparam logic [C_SIZE_W-1:0] C_SIZE_RESET = 13'd4096;

    localparam logic C_REG_MAP_WIDTH  = 1'b0;
    localparam logic C_REG_MAP_HEIGHT = 1'b1;

    typedef enum logic [C_PAT_W-1:0] {
        PAT_FOUR   = 2'd0,
        PAT_EIGHT  = 2'd1,
        PAT_WINDOW = 2'd2
    } t_pattern;

    // offsets are held as index = offset + 2
    localparam logic [C_OFF_W-1:0] C_STEP_XI [8] = '{
        3'd2, 3'd3, 3'd1, 3'd2, 3'd3, 3'd3, 3'd1, 3'd1
    };
    localparam logic [C_OFF_W-1:0] C_STEP_YI [8] = '{
        3'd3, 3'd2, 3'd2, 3'd1, 3'd3, 3'd1, 3'd3, 3'd1
    };
    localparam logic [C_OFF_W-1:0] C_WIN_XI [C_SLOTS] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1,       3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4
    };
    localparam logic [C_OFF_W-1:0] C_WIN_YI [C_SLOTS] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2,       3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };

    typedef struct packed {
        logic               en;
        logic [C_OFF_W-1:0] xi;
        logic [C_OFF_W-1:0] yi;
    } t_off;

    typedef struct packed {
        logic [C_COORD_W-1:0] cx;
        logic [C_COORD_W-1:0] cy;
        logic [C_PAT_W-1:0]   pattern;
        logic [C_SLOTS-1:0]   mask;
    } t_cmd;

    typedef struct packed {
        logic [C_COORD_W-1:0] nbr_x;
        logic [C_COORD_W-1:0] nbr_y;
        logic                 last;
    } t_res;

    function automatic t_off slot_offset(input logic [C_PAT_W-1:0] pat,
                                         input logic [C_SLOT_W-1:0] slot);
        t_off r;
        r = '0;
        case (t_pattern'(pat))
            PAT_FOUR: begin
                if (slot < C_SLOT_W'(4)) begin
                    r.en = 1'b1;
                    r.xi = C_STEP_XI[slot[2:0]];
                    r.yi = C_STEP_YI[slot[2:0]];
                end
            end
            PAT_EIGHT: begin
                if (slot < C_SLOT_W'(8)) begin
                    r.en = 1'b1;
                    r.xi = C_STEP_XI[slot[2:0]];
                    r.yi = C_STEP_YI[slot[2:0]];
                end
            end
            PAT_WINDOW: begin
                if (slot < C_SLOT_W'(C_SLOTS)) begin
                    r.en = 1'b1;
                    r.xi = C_WIN_XI[slot];
                    r.yi = C_WIN_YI[slot];
                end
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/gne_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gne_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/gne_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gne_front
    import gne_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire logic [C_COORD_W-1:0] i_cell_x,
    input  wire logic [C_COORD_W-1:0] i_cell_y,
    input  wire logic [C_PAT_W-1:0]   i_pattern,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_index,
    input  wire logic [C_SIZE_W-1:0]  i_cfg_data,
    input  wire logic                 i_cmd_full,
    output logic                      o_cmd_push,
    output t_cmd                      o_cmd
);

    logic [C_SIZE_W-1:0]  r_map_width;
    logic [C_SIZE_W-1:0]  r_map_height;
    logic [C_SIZE_W-1:0]  width_eff;
    logic [C_SIZE_W-1:0]  height_eff;
    logic [C_REACH_N-1:0] x_ok;
    logic [C_REACH_N-1:0] y_ok;
    logic [C_SLOTS-1:0]   mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= C_SIZE_RESET;
            r_map_height <= C_SIZE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == C_REG_MAP_WIDTH) begin
                r_map_width <= i_cfg_data;
            end
            if (i_cfg_index == C_REG_MAP_HEIGHT) begin
                r_map_height <= i_cfg_data;
            end
        end
    end

    assign width_eff  = (r_map_width  > C_SIZE_CAP) ? C_SIZE_CAP : r_map_width;
    assign height_eff = (r_map_height > C_SIZE_CAP) ? C_SIZE_CAP : r_map_height;

    // per-axis inside test for each offset -2..+2
    always_comb begin
        logic [C_SIZE_W:0] nx;
        logic [C_SIZE_W:0] ny;
        for (int k = 0; k < C_REACH_N; k++) begin
            nx = {2'b00, i_cell_x} + (C_SIZE_W + 1)'(k) - (C_SIZE_W + 1)'(2);
            ny = {2'b00, i_cell_y} + (C_SIZE_W + 1)'(k) - (C_SIZE_W + 1)'(2);
            x_ok[k] = !nx[C_SIZE_W] && (nx < {1'b0, width_eff});
            y_ok[k] = !ny[C_SIZE_W] && (ny < {1'b0, height_eff});
        end
    end

    always_comb begin
        t_off off;
        for (int s = 0; s < C_SLOTS; s++) begin
            off     = slot_offset(i_pattern, C_SLOT_W'(s));
            mask[s] = off.en && x_ok[off.xi] && y_ok[off.yi];
        end
    end

    // items with nothing inside the map are taken and dropped here
    assign o_cmd_push    = i_push && !i_cmd_full && (mask != '0);
    assign o_cmd.cx      = i_cell_x;
    assign o_cmd.cy      = i_cell_y;
    assign o_cmd.pattern = i_pattern;
    assign o_cmd.mask    = mask;

endmodule

`default_nettype wire

@@ rtl/gne_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gne_back
    import gne_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    input  wire logic i_res_full,
    output logic      o_res_push,
    output t_res      o_res
);

    logic                 r_busy;
    logic [C_COORD_W-1:0] r_cx;
    logic [C_COORD_W-1:0] r_cy;
    logic [C_PAT_W-1:0]   r_pattern;
    logic [C_SLOTS-1:0]   r_mask;
    logic [C_SLOT_W-1:0]  slot;
    logic [C_SLOTS-1:0]   rem_next;
    t_off                 off;
    logic                 emit;
    logic                 done;
    logic                 load;

    // lowest pending slot goes next
    always_comb begin
        slot = '0;
        for (int s = C_SLOTS - 1; s >= 0; s--) begin
            if (r_mask[s]) begin
                slot = C_SLOT_W'(s);
            end
        end
    end

    assign off      = slot_offset(r_pattern, slot);
    assign rem_next = r_mask & ~(C_SLOTS'(1) << slot);
    assign emit     = r_busy && !i_res_full;
    assign done     = emit && (rem_next == '0);
    assign load     = i_cmd_valid && (!r_busy || done);

    assign o_cmd_pop   = load;
    assign o_res_push  = emit;
    assign o_res.nbr_x = r_cx + C_COORD_W'(off.xi) - C_COORD_W'(2);
    assign o_res.nbr_y = r_cy + C_COORD_W'(off.yi) - C_COORD_W'(2);
    assign o_res.last  = (rem_next == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cx      <= i_cmd.cx;
            r_cy      <= i_cmd.cy;
            r_pattern <= i_cmd.pattern;
            r_mask    <= i_cmd.mask;
        end else if (emit) begin
            r_mask <= rem_next;
        end
    end

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_mask != '0))
        else $error("walker busy with empty mask");

    a_emit_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (r_busy && !i_res_full))
        else $error("result pushed while idle or blocked");

    a_load_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> r_busy)
        else $error("command taken but walker not busy");

    a_pop_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && r_busy) |-> o_res.last)
        else $error("command taken before current run finished");

endmodule

`default_nettype wire

@@ rtl/grid_neighbour_enumerator.sv @@
// Each item passes the command queue and the walker registers, and each result passes
// the result queue. Throughput: one result per cycle while the result queue is not full;
// the walker yields an item's 1 to 24 in-map neighbours; items with none never reach it.
// The command queue lets intake run ahead of the walker by CMD_DEPTH items.
// Reset (synchronous, active low) empties both queues and sets both map sizes to 4096.
`timescale 1ns / 1ps
`default_nettype none

module grid_neighbour_enumerator
    import gne_pkg::*;
#(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [C_COORD_W-1:0] i_cell_x,
    input  wire logic [C_COORD_W-1:0] i_cell_y,
    input  wire logic [C_PAT_W-1:0]   i_pattern,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [C_COORD_W-1:0]      o_nbr_x,
    output logic [C_COORD_W-1:0]      o_nbr_y,
    output logic                      o_last,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_index,
    input  wire logic [C_SIZE_W-1:0]  i_cfg_data
);

    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;
    t_cmd cmd_in;
    t_cmd cmd_out;
    logic res_push;
    logic res_full;
    t_res res_in;
    t_res res_out;

    gne_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cell_x    (i_cell_x),
        .i_cell_y    (i_cell_y),
        .i_pattern   (i_pattern),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_full  (cmd_full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    gne_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    gne_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    gne_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign full    = cmd_full;
    assign o_nbr_x = res_out.nbr_x;
    assign o_nbr_y = res_out.nbr_y;
    assign o_last  = res_out.last;

endmodule

`default_nettype wire
